### sv/hcbd_pkg.sv
`default_nettype none

package hcbd_pkg;

    localparam int SIZE_BITS  = 32;
    localparam int COUNT_BITS = 32;
    localparam int LIMIT_BITS = 32;
    localparam int CMP_BITS   = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
    localparam int SKIP_COUNT = 2;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef enum logic [4:0] {
        PH_SIZE = 5'b00001,
        PH_DATA = 5'b00010,
        PH_SKIP = 5'b00100,
        PH_DONE = 5'b01000,
        PH_BIG  = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        ST_BUSY = 2'd0,
        ST_DONE = 2'd1,
        ST_BIG  = 2'd2
    } status_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        status_t    status;
    } result_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] nibble;
    } hex_t;

    function automatic hex_t hex_value(input logic [7:0] b);
        hex_t h;
        h.is_hex = 1'b1;
        h.nibble = 4'd0;
        if (b inside {[8'h30:8'h39]})
        begin
            h.nibble = 4'(b - 8'h30);
        end
        else if (b inside {[8'h61:8'h66]})
        begin
            h.nibble = 4'(b - 8'h57);
        end
        else if (b inside {[8'h41:8'h46]})
        begin
            h.nibble = 4'(b - 8'h37);
        end
        else
        begin
            h.is_hex = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

### sv/http_chunked_body_decoder_top.sv
`default_nettype none

// HTTP chunked body decoder. Feed the raw bytes of a chunked message body,
// one per beat, on body_byte; every accepted byte yields exactly one result
// beat carrying payload_valid, payload_byte and status, in order. Hex chunk
// sizes are gathered (saturating) up to the first non-hex byte, the size
// line ends on CR LF, data bytes are passed with payload_valid high, and the
// two bytes after each chunk are dropped unchecked. A zero-size chunk ends
// the body with status 1; a nonzero max_body_bytes that the payload total
// exceeds gives a sticky status 2. After either, bytes are consumed and
// answered with payload_valid low. The block sustains one byte per clock
// while result_stall is low: a byte is held in the input register, and the
// phase and counter update is combinational logic into the result register,
// so a new byte can enter while the held byte moves on to its result.
// Write max_body_bytes only while the block is idle; cfg_ready is always high.

module http_chunked_body_decoder_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            body_valid,
    output      logic                            body_stall,
    input  wire logic [7:0]                      body_byte,
    output      logic                            result_valid,
    input  wire logic                            result_stall,
    output      logic                            payload_valid,
    output      logic [7:0]                      payload_byte,
    output      logic [1:0]                      status,
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [hcbd_pkg::LIMIT_BITS-1:0] max_body_bytes
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    hcbd_pkg::result_t out_res_reg;
    hcbd_pkg::result_t core_res;

    logic              advance;
    logic              fire;
    logic              take;

    // The result register can take a new beat when empty or being drained.
    assign advance = !out_valid_reg || !result_stall;
    // Process the held byte only when its result has somewhere to go.
    assign fire    = in_valid_reg && advance;
    // Stall the input only when the held byte cannot move on.
    assign body_stall = in_valid_reg && !advance;
    assign take       = body_valid && !body_stall;

    assign cfg_ready = 1'b1;

    hcbd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .data_byte (in_byte_reg),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (max_body_bytes),
        .res       (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take || fire)
            begin
                in_valid_reg <= take;
            end
            if (advance)
            begin
                out_valid_reg <= fire;
            end
        end
    end

    // Payload registers: load on their beat, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_byte_reg <= body_byte;
        end
        if (fire)
        begin
            out_res_reg <= core_res;
        end
    end

    assign result_valid  = out_valid_reg;
    assign payload_valid = out_res_reg.payload_valid;
    assign payload_byte  = out_res_reg.payload_byte;
    assign status        = out_res_reg.status;

endmodule

`default_nettype wire

### sv/hcbd_core.sv
`default_nettype none

module hcbd_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           fire,
    input  wire logic [7:0]                     data_byte,
    input  wire logic                           cfg_write,
    input  wire logic [hcbd_pkg::LIMIT_BITS-1:0] cfg_data,
    output hcbd_pkg::result_t                   res
);

    hcbd_pkg::phase_t                   phase_reg, phase_next;
    logic [hcbd_pkg::SIZE_BITS-1:0]     chunk_reg, chunk_next;
    logic [hcbd_pkg::COUNT_BITS-1:0]    total_reg, total_next;
    logic                               stopped_reg, stopped_next;
    logic                               cr_reg, cr_next;
    logic [1:0]                         skip_reg, skip_next;
    logic [hcbd_pkg::LIMIT_BITS-1:0]    limit_reg;

    hcbd_pkg::hex_t                     hex;
    logic [hcbd_pkg::SIZE_BITS-1:0]     chunk_acc;
    logic [hcbd_pkg::COUNT_BITS-1:0]    total_inc;
    logic                               over_limit;

    assign hex = hcbd_pkg::hex_value(data_byte);

    // saturate once the top nibble is occupied
    assign chunk_acc = (chunk_reg[hcbd_pkg::SIZE_BITS-1 -: 4] != 4'd0) ? '1
                     : {chunk_reg[hcbd_pkg::SIZE_BITS-5:0], hex.nibble};

    assign total_inc = (&total_reg) ? total_reg
                     : total_reg + hcbd_pkg::COUNT_BITS'(1);

    assign over_limit = (limit_reg != '0) &&
        (hcbd_pkg::CMP_BITS'(total_inc) > hcbd_pkg::CMP_BITS'(limit_reg));

    always_comb
    begin
        phase_next        = phase_reg;
        chunk_next        = chunk_reg;
        total_next        = total_reg;
        stopped_next      = stopped_reg;
        cr_next           = cr_reg;
        skip_next         = skip_reg;
        res.payload_valid = 1'b0;
        res.payload_byte  = 8'd0;
        res.status        = hcbd_pkg::ST_BUSY;
        case (phase_reg)
            hcbd_pkg::PH_SIZE:
            begin
                if (!stopped_reg && hex.is_hex)
                begin
                    chunk_next = chunk_acc;
                    cr_next    = 1'b0;
                end
                else
                begin
                    stopped_next = 1'b1;
                    if (cr_reg && data_byte == hcbd_pkg::CHAR_LF)
                    begin
                        cr_next = 1'b0;
                        if (chunk_reg == '0)
                        begin
                            phase_next = hcbd_pkg::PH_DONE;
                            res.status = hcbd_pkg::ST_DONE;
                        end
                        else
                        begin
                            phase_next = hcbd_pkg::PH_DATA;
                        end
                    end
                    else
                    begin
                        cr_next = (data_byte == hcbd_pkg::CHAR_CR);
                    end
                end
            end
            hcbd_pkg::PH_DATA:
            begin
                res.payload_valid = 1'b1;
                res.payload_byte  = data_byte;
                total_next        = total_inc;
                if (chunk_reg != '0)
                begin
                    chunk_next = chunk_reg - hcbd_pkg::SIZE_BITS'(1);
                end
                if (over_limit)
                begin
                    phase_next = hcbd_pkg::PH_BIG;
                    res.status = hcbd_pkg::ST_BIG;
                end
                else if (chunk_next == '0)
                begin
                    phase_next = hcbd_pkg::PH_SKIP;
                    skip_next  = 2'(hcbd_pkg::SKIP_COUNT);
                end
            end
            hcbd_pkg::PH_SKIP:
            begin
                if (skip_reg != 2'd0)
                begin
                    skip_next = skip_reg - 2'd1;
                end
                if (skip_next == 2'd0)
                begin
                    phase_next   = hcbd_pkg::PH_SIZE;
                    chunk_next   = '0;
                    stopped_next = 1'b0;
                    cr_next      = 1'b0;
                end
            end
            hcbd_pkg::PH_DONE:
            begin
                res.status = hcbd_pkg::ST_DONE;
            end
            default:
            begin
                phase_next = hcbd_pkg::PH_BIG;
                res.status = hcbd_pkg::ST_BIG;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= hcbd_pkg::PH_SIZE;
            chunk_reg   <= '0;
            total_reg   <= '0;
            stopped_reg <= 1'b0;
            cr_reg      <= 1'b0;
            skip_reg    <= 2'd0;
            limit_reg   <= '0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg   <= phase_next;
                chunk_reg   <= chunk_next;
                total_reg   <= total_next;
                stopped_reg <= stopped_next;
                cr_reg      <= cr_next;
                skip_reg    <= skip_next;
            end
            if (cfg_write)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

endmodule

`default_nettype wire
